// ===== sv/svs_pkg.sv =====
// shared types and constants for the sectioned voxel store
// no dependencies; imported by the voxel ram, the core and the checker
package svs_pkg;

  localparam int VOXEL_W        = 8;
  localparam int SOLID_W        = 13;
  localparam int POS_W          = 4;
  localparam int POS_Y_W        = 10;
  localparam int LAYER_W        = 4;
  localparam int SECTION_LAYERS = 16;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [VOXEL_W-1:0] AIR = '0;

  typedef enum logic {
    MS_CLEAR,
    MS_RUN
  } mem_state_t;

endpackage

// ===== sv/svs_voxel_ram.sv =====
// voxel byte ram with one read and one write port and a clearing sweep after reset
// depends on svs_pkg
module svs_voxel_ram
  import svs_pkg::*;
#(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [VOXEL_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VOXEL_W-1:0] wr_data,
  output logic               ready
);

  logic [VOXEL_W-1:0] mem [DEPTH];
  logic [VOXEL_W-1:0] rd_data_r;

  mem_state_t        st_r, st_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_we;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      MS_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) st_nxt = MS_RUN;
      end
      MS_RUN:   st_nxt = MS_RUN;
      default:  st_nxt = MS_CLEAR;
    endcase
  end

  always_comb begin
    clr_we       = 1'b0;
    ready        = 1'b0;
    clr_addr_nxt = clr_addr_r;
    unique case (st_r)
      MS_CLEAR: begin
        clr_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      MS_RUN: begin
        ready = 1'b1;
      end
      default: begin
        clr_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= MS_CLEAR;
      clr_addr_r <= '0;
    end else begin
      st_r       <= st_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[clr_addr_r] <= AIR;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/sectioned_voxel_store_core.sv =====
// throughput: one item per cycle while the output is taken; an accepted item passes
// the stage 1 register, then the output register. each item reads the voxel ram (one
// read and one write port); a write that changes the byte writes it back, with the last
// write forwarded to the next item. reset: section counts clear at once; the voxel ram
// is swept to air after reset, with in_stall high meanwhile
module sectioned_voxel_store_core
  import svs_pkg::*;
#(
  parameter int WIDTH_X       = 16,
  parameter int COLUMN_HEIGHT = 256,
  parameter int DEPTH_Z       = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic [POS_W-1:0]          in_pos_x,
  input  logic signed [POS_Y_W-1:0] in_pos_y,
  input  logic [POS_W-1:0]          in_pos_z,
  input  logic [VOXEL_W-1:0]        in_new_type,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [VOXEL_W-1:0]        out_voxel_value,
  output logic [SOLID_W-1:0]        out_section_solid
);

  localparam int NUM_SECTIONS = COLUMN_HEIGHT / SECTION_LAYERS;
  localparam int SECTION_SIZE = WIDTH_X * SECTION_LAYERS * DEPTH_Z;
  localparam int MEM_DEPTH    = NUM_SECTIONS * SECTION_SIZE;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int SEC_W        = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CNT_W        = $clog2(SECTION_SIZE + 1);
  localparam int USED_HEIGHT  = NUM_SECTIONS * SECTION_LAYERS;

  // address decode of the incoming item
  logic              in_acc;
  logic              y_ok, xz_ok;
  logic [SEC_W-1:0]  sec;
  logic [ADDR_W-1:0] addr;

  // stage 1: ram data available
  logic               s1_v_r, s1_v_nxt;
  logic               s1_func_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [SEC_W-1:0]   s1_sec_r;
  logic               s1_y_ok_r, s1_xz_ok_r;
  logic [VOXEL_W-1:0] s1_new_r;
  logic               s1_done;

  logic [VOXEL_W-1:0] rd_data;
  logic               ram_ready;
  logic               wr_en;

  logic               fw_v_r;
  logic [ADDR_W-1:0]  fw_addr_r;
  logic [VOXEL_W-1:0] fw_data_r;

  logic [CNT_W-1:0]   counts_r [NUM_SECTIONS];

  logic [VOXEL_W-1:0] old_val, val;
  logic [CNT_W-1:0]   cnt_cur, cnt_upd;
  logic               hit, do_wr;
  logic [SOLID_W-1:0] solid;

  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  logic [VOXEL_W-1:0] out_voxel_value_r;
  logic [SOLID_W-1:0] out_section_solid_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_done  = s1_v_r && out_free;
  assign in_stall = !ram_ready || (s1_v_r && !out_free);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    y_ok  = !in_pos_y[POS_Y_W-1] &&
            ({1'b0, in_pos_y[POS_Y_W-2:0]} < POS_Y_W'(USED_HEIGHT));
    xz_ok = ({28'd0, in_pos_x} < 32'(WIDTH_X)) && ({28'd0, in_pos_z} < 32'(DEPTH_Z));
    sec   = in_pos_y[LAYER_W +: SEC_W];
    addr  = ADDR_W'(sec) * ADDR_W'(SECTION_SIZE)
          + ADDR_W'(in_pos_x)
          + ADDR_W'(in_pos_y[LAYER_W-1:0]) * ADDR_W'(WIDTH_X)
          + ADDR_W'(in_pos_z) * ADDR_W'(SECTION_LAYERS * WIDTH_X);
  end

  svs_voxel_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_new_r),
    .ready   (ram_ready)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_done) begin
      s1_v_nxt = 1'b0;
    end
  end

  // modify step; the ram read raced the previous write, so on an address match take the forwarded byte
  always_comb begin
    old_val = (fw_v_r && fw_addr_r == s1_addr_r) ? fw_data_r : rd_data;
    cnt_cur = counts_r[s1_sec_r];
    hit     = s1_y_ok_r && s1_xz_ok_r;
    do_wr   = hit && (s1_func_r == FUNC_WRITE) && (old_val != s1_new_r);
    cnt_upd = cnt_cur;
    if (do_wr && old_val == AIR) begin
      cnt_upd = cnt_cur + 1'b1;
    end else if (do_wr && s1_new_r == AIR && cnt_cur != '0) begin
      cnt_upd = cnt_cur - 1'b1;
    end
    val = AIR;
    if (hit) begin
      val = do_wr ? s1_new_r : old_val;
    end
    // an empty section reads as air
    if (cnt_upd == '0) begin
      val = AIR;
    end
    solid = s1_y_ok_r ? SOLID_W'(cnt_upd) : '0;
  end

  assign wr_en = s1_done && do_wr;

  assign out_valid_nxt = s1_done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      fw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        fw_v_r             <= 1'b1;
        counts_r[s1_sec_r] <= cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_func;
      s1_addr_r  <= addr;
      s1_sec_r   <= sec;
      s1_y_ok_r  <= y_ok;
      s1_xz_ok_r <= xz_ok;
      s1_new_r   <= in_new_type;
    end
    if (wr_en) begin
      fw_addr_r <= s1_addr_r;
      fw_data_r <= s1_new_r;
    end
    if (s1_done) begin
      out_voxel_value_r   <= val;
      out_section_solid_r <= solid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_voxel_value   = out_voxel_value_r;
  assign out_section_solid = out_section_solid_r;

endmodule

// ===== sv/svs_checker.sv =====
// port-level checks for the sectioned voxel store core, bound to the top level
// depends on svs_pkg and sectioned_voxel_store_core
module svs_checker
  import svs_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [VOXEL_W-1:0]        out_voxel_value,
  input logic [SOLID_W-1:0]        out_section_solid
);

  // reset starts the clearing sweep, which holds off input items
  a_reset_stalls: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_voxel_value) &&
      $stable(out_section_solid))
    else $error("stalled result item changed");

  // an idle output gets a result only from an accepted item, passed through the stage 1 and output registers
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result item without an accepted input item");

  a_empty_air: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_section_solid == '0 |-> out_voxel_value == AIR)
    else $error("solid voxel reported in an empty section");

endmodule

bind sectioned_voxel_store_core svs_checker u_svs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_voxel_value   (out_voxel_value),
  .out_section_solid (out_section_solid)
);
